[hdl/lbmi_pkg.sv]
package lbmi_pkg;

   localparam int TABLE_MAX = 16;
   localparam int IDX_W     = 4;
   localparam int Y_W       = 13;
   localparam int RATE_W    = 16;
   localparam int SPEED_W   = 16;
   localparam int CODE_W    = 8;
   localparam int BAND_W    = 2;
   localparam int MAP_W     = 21;
   localparam int CURVE_W   = 12;
   localparam int CSR_IDX_W = 2;

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [Y_W-1:0]     y_type;
   typedef logic [BAND_W-1:0]  band_type;
   typedef logic [SPEED_W-1:0] speed_type;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_RATE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_RATE = 2'd1;

   localparam logic signed [RATE_W-1:0] LOW_RATE_RESET  = 16'sd1280;
   localparam logic signed [RATE_W-1:0] HIGH_RATE_RESET = 16'sd1664;

   localparam logic [CODE_W-1:0] OVERRIDE_FORCE = 8'd1;
   localparam logic [CODE_W-1:0] MODE_LATCH     = 8'd2;

   localparam band_type BAND_OVERRIDE = 2'd0;
   localparam band_type BAND_LOW      = 2'd1;
   localparam band_type BAND_MID      = 2'd2;
   localparam band_type BAND_HIGH     = 2'd3;

   // Lower two grid rows are flat; upper two follow the shaped row.
   function automatic y_type grid_value(band_type row, idx_type col);
      y_type v;
      if (row == BAND_OVERRIDE || row == BAND_LOW) begin
         v = 13'd5000;
      end else begin
         case (col)
            4'd0:    v = 13'd10;
            4'd1:    v = 13'd30;
            4'd2:    v = 13'd30;
            4'd3:    v = 13'd15;
            4'd4:    v = 13'd12;
            default: v = 13'd5;
         endcase
      end
      return v;
   endfunction

   function automatic y_type curve_point(idx_type col);
      y_type v;
      case (col)
         4'd0:    v = 13'd3;
         4'd1:    v = 13'd9;
         4'd2:    v = 13'd6;
         default: v = 13'd4;
      endcase
      return v;
   endfunction

endpackage

[hdl/lbmi_classify.sv]
module lbmi_classify (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 in_valid,
   input  logic signed [lbmi_pkg::RATE_W-1:0]   rate,
   input  lbmi_pkg::speed_type                  speed,
   input  logic [lbmi_pkg::CODE_W-1:0]          override_code,
   input  logic [lbmi_pkg::CODE_W-1:0]          mode_code,
   input  logic signed [lbmi_pkg::RATE_W-1:0]   low_thr,
   input  logic signed [lbmi_pkg::RATE_W-1:0]   high_thr,
   output logic                                 out_valid,
   output lbmi_pkg::band_type                   band,
   output lbmi_pkg::speed_type                  latched,
   output lbmi_pkg::speed_type                  speed_out
);
   import lbmi_pkg::*;

   logic      valid_ff;
   band_type  band_ff, band_in;
   speed_type latched_ff, latched_in;
   speed_type speed_ff;

   always_comb begin
      if (override_code == OVERRIDE_FORCE) begin
         band_in = BAND_OVERRIDE;
      end else if (rate > low_thr) begin
         band_in = (high_thr > rate) ? BAND_MID : BAND_HIGH;
      end else begin
         band_in = BAND_LOW;
      end
      latched_in = (mode_code == MODE_LATCH) ? speed : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         band_ff    <= band_in;
         latched_ff <= latched_in;
         speed_ff   <= speed;
      end
   end

   assign out_valid = valid_ff;
   assign band      = band_ff;
   assign latched   = latched_ff;
   assign speed_out = speed_ff;
endmodule

[hdl/lbmi_lookup.sv]
module lbmi_lookup #(
   parameter int MAP_COLUMNS   = 7,
   parameter int MAP_ROWS      = 4,
   parameter int CURVE_POINTS  = 6,
   parameter int FRACTION_BITS = 8
) (
   input  logic                       clock,
   input  logic                       advance,
   input  lbmi_pkg::band_type         band,
   input  lbmi_pkg::speed_type        latched,
   input  lbmi_pkg::speed_type        speed,
   output lbmi_pkg::y_type            map_y0,
   output lbmi_pkg::y_type            map_y1,
   output logic [FRACTION_BITS-1:0]   map_frac,
   output lbmi_pkg::y_type            curve_y0,
   output lbmi_pkg::y_type            curve_y1,
   output logic [FRACTION_BITS-1:0]   curve_frac
);
   import lbmi_pkg::*;

   localparam int IP_W = SPEED_W - FRACTION_BITS;
   localparam logic [IP_W-1:0] MAP_LAST   = IP_W'(MAP_COLUMNS - 1);
   localparam logic [IP_W-1:0] CURVE_LAST = IP_W'(CURVE_POINTS - 1);
   localparam band_type        ROW_LAST   = BAND_W'(MAP_ROWS - 1);

   logic [IP_W-1:0]          map_ip, speed_ip, curve_ip;
   idx_type                  map_idx, map_next, curve_idx, curve_next;
   band_type                 row;
   logic [FRACTION_BITS-1:0] map_frac_in, curve_frac_in;

   y_type                    map_y0_ff, map_y1_ff, curve_y0_ff, curve_y1_ff;
   logic [FRACTION_BITS-1:0] map_frac_ff, curve_frac_ff;

   always_comb begin
      map_ip   = latched[SPEED_W-1:FRACTION_BITS];
      speed_ip = speed[SPEED_W-1:FRACTION_BITS];
      curve_ip = speed_ip - IP_W'(1);

      row = (band > ROW_LAST) ? ROW_LAST : band;

      // Clamp to the last column at or past the end of the axis
      if (map_ip >= MAP_LAST) begin
         map_idx     = IDX_W'(MAP_COLUMNS - 1);
         map_frac_in = '0;
      end else begin
         map_idx     = map_ip[IDX_W-1:0];
         map_frac_in = latched[FRACTION_BITS-1:0];
      end
      map_next = map_idx + IDX_W'(map_frac_in != '0);

      // Curve axis starts at one: below it, hold the first point
      if (speed_ip == '0) begin
         curve_idx     = '0;
         curve_frac_in = '0;
      end else if (curve_ip >= CURVE_LAST) begin
         curve_idx     = IDX_W'(CURVE_POINTS - 1);
         curve_frac_in = '0;
      end else begin
         curve_idx     = curve_ip[IDX_W-1:0];
         curve_frac_in = speed[FRACTION_BITS-1:0];
      end
      curve_next = curve_idx + IDX_W'(curve_frac_in != '0);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         map_y0_ff     <= grid_value(row, map_idx);
         map_y1_ff     <= grid_value(row, map_next);
         map_frac_ff   <= map_frac_in;
         curve_y0_ff   <= curve_point(curve_idx);
         curve_y1_ff   <= curve_point(curve_next);
         curve_frac_ff <= curve_frac_in;
      end
   end

   assign map_y0     = map_y0_ff;
   assign map_y1     = map_y1_ff;
   assign map_frac   = map_frac_ff;
   assign curve_y0   = curve_y0_ff;
   assign curve_y1   = curve_y1_ff;
   assign curve_frac = curve_frac_ff;
endmodule

[hdl/lbmi_lerp.sv]
module lbmi_lerp #(
   parameter int FRACTION_BITS = 8,
   parameter int OUT_W         = 21
) (
   input  logic                       clock,
   input  logic                       advance,
   input  lbmi_pkg::y_type            y0,
   input  lbmi_pkg::y_type            y1,
   input  logic [FRACTION_BITS-1:0]   frac,
   output logic [OUT_W-1:0]           result
);
   import lbmi_pkg::*;

   localparam int P_W   = Y_W + FRACTION_BITS + 2;
   localparam int ACC_W = 32;

   logic signed [Y_W:0]           diff;
   logic signed [FRACTION_BITS:0] frac_s;
   logic signed [P_W-1:0]         prod_in, prod_ff;
   y_type                         y0_ff;
   logic signed [P_W-1:0]         base;
   logic signed [ACC_W-1:0]       sum;
   logic [OUT_W-1:0]              result_ff;

   always_comb begin
      diff    = signed'({1'b0, y1}) - signed'({1'b0, y0});
      frac_s  = signed'({1'b0, frac});
      prod_in = frac_s * diff;
      base    = signed'({2'b0, y0_ff, {FRACTION_BITS{1'b0}}});
      sum     = ACC_W'(base) + ACC_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff   <= prod_in;
         y0_ff     <= y0;
         result_ff <= sum[OUT_W-1:0];
      end
   end

   assign result = result_ff;
endmodule

[hdl/liftoff_band_and_map_interp_core.sv]
// Liftoff band classifier with map and curve interpolation.
//
// Input stream (req_*): one item per sample set. tdata carries the signed
// Q8.8 throttle rate and the unsigned engine speed; tuser carries the
// override byte and the mode byte. Result stream (rsp_*): one item per
// input item, in order, with band, latched speed, map value and curve value.
// Configuration (csr_*): index 0 writes the low rate threshold, index 1 the
// high one; other indexes are dropped. csr_ready is always high; write only
// while no item is in flight.
//
// Each accepted item passes through the classify, table lookup, multiply and
// add registers before rsp_tvalid. One item is accepted every cycle while the
// receiver takes results, so throughput is one item per clock.
// When the receiver stalls, the whole pipeline holds and req_tready drops;
// nothing is lost or repeated. Reset clears all valid bits and restores
// both thresholds (5.0 and 6.5 in Q8.8).
module liftoff_band_and_map_interp_core #(
   parameter int MAP_COLUMNS   = 7,
   parameter int MAP_ROWS      = 4,
   parameter int CURVE_POINTS  = 6,
   parameter int FRACTION_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: throttle_rate[15:0], engine_speed[31:16]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [31:0]                        req_tdata,
   // req_tuser: override_code[7:0], mode_code[15:8]
   input  logic [15:0]                        req_tuser,
   // rsp_tdata: liftoff_band[1:0], latched_speed[17:2], map_value[38:18],
   //            curve_value[50:39], zero fill[55:51]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [55:0]                        rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lbmi_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [15:0]                        csr_data
);
   import lbmi_pkg::*;

   // Threshold registers
   logic signed [RATE_W-1:0] low_thr_ff, high_thr_ff;

   // Whole pipeline moves together; the output register frees on a take
   logic advance;

   logic      s1_valid;
   band_type  s1_band;
   speed_type s1_latched, s1_speed;

   logic      s2_valid_ff;
   band_type  s2_band_ff;
   speed_type s2_latched_ff;

   logic      s3_valid_ff;
   band_type  s3_band_ff;
   speed_type s3_latched_ff;

   logic      s4_valid_ff;
   band_type  s4_band_ff;
   speed_type s4_latched_ff;

   y_type                    map_y0, map_y1, curve_y0, curve_y1;
   logic [FRACTION_BITS-1:0] map_frac, curve_frac;
   logic [MAP_W-1:0]         map_value;
   logic [CURVE_W-1:0]       curve_value;

   assign advance    = !s4_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_thr_ff  <= LOW_RATE_RESET;
         high_thr_ff <= HIGH_RATE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LOW_RATE:  low_thr_ff  <= signed'(csr_data);
            CSR_HIGH_RATE: high_thr_ff <= signed'(csr_data);
            default: ;
         endcase
      end
   end

   // Stage 1: band and latched speed
   lbmi_classify u_classify (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (req_tvalid),
      .rate          (signed'(req_tdata[15:0])),
      .speed         (req_tdata[31:16]),
      .override_code (req_tuser[7:0]),
      .mode_code     (req_tuser[15:8]),
      .low_thr       (low_thr_ff),
      .high_thr      (high_thr_ff),
      .out_valid     (s1_valid),
      .band          (s1_band),
      .latched       (s1_latched),
      .speed_out     (s1_speed)
   );

   // Stage 2: axis split and table reads
   lbmi_lookup #(
      .MAP_COLUMNS   (MAP_COLUMNS),
      .MAP_ROWS      (MAP_ROWS),
      .CURVE_POINTS  (CURVE_POINTS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_lookup (
      .clock      (clock),
      .advance    (advance),
      .band       (s1_band),
      .latched    (s1_latched),
      .speed      (s1_speed),
      .map_y0     (map_y0),
      .map_y1     (map_y1),
      .map_frac   (map_frac),
      .curve_y0   (curve_y0),
      .curve_y1   (curve_y1),
      .curve_frac (curve_frac)
   );

   // Stages 3 and 4: multiply, then add the base point
   lbmi_lerp #(
      .FRACTION_BITS (FRACTION_BITS),
      .OUT_W         (MAP_W)
   ) u_map_lerp (
      .clock   (clock),
      .advance (advance),
      .y0      (map_y0),
      .y1      (map_y1),
      .frac    (map_frac),
      .result  (map_value)
   );

   lbmi_lerp #(
      .FRACTION_BITS (FRACTION_BITS),
      .OUT_W         (CURVE_W)
   ) u_curve_lerp (
      .clock   (clock),
      .advance (advance),
      .y0      (curve_y0),
      .y1      (curve_y1),
      .frac    (curve_frac),
      .result  (curve_value)
   );

   // Carry valid, band and latched speed alongside the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
      if (advance) begin
         s2_band_ff    <= s1_band;
         s2_latched_ff <= s1_latched;
         s3_band_ff    <= s2_band_ff;
         s3_latched_ff <= s2_latched_ff;
         s4_band_ff    <= s3_band_ff;
         s4_latched_ff <= s3_latched_ff;
      end
   end

   assign rsp_tvalid = s4_valid_ff;
   assign rsp_tdata  = {5'b0, curve_value, map_value, s4_latched_ff, s4_band_ff};
endmodule

[hdl/lbmi_checker.sv]
module lbmi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic [15:0] req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [1:0]  csr_index,
   input logic [15:0] csr_data
);
   import lbmi_pkg::*;

   // Output register empties after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Input is taken whenever the output register is free or being taken
   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow output side");

   // Override item comes out with band zero after the pipeline, if never stalled
   a_override_band: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[7:0] == OVERRIDE_FORCE
      ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready
      |=> rsp_tvalid && rsp_tdata[1:0] == BAND_OVERRIDE)
      else $error("override item lost or band not zero");

   // Item not in latch mode comes out with zero latched speed
   a_mode_latch: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[15:8] != MODE_LATCH
      ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready
      |=> rsp_tvalid && rsp_tdata[17:2] == 16'd0)
      else $error("latched speed not zero outside latch mode");

endmodule

bind liftoff_band_and_map_interp_core lbmi_checker u_lbmi_checker (.*);
